// ===== hdl/qsve_pkg.sv =====
package qsve_pkg;

  localparam int GATE_W    = 18;
  localparam int GATE_FRAC = 16;
  localparam int IDX_W     = 6;
  localparam int DRAW_W    = 16;
  localparam int QCFG_W    = 3;
  localparam int CMD_W     = 3;

  localparam logic [QCFG_W-1:0] QCFG_RESET = 3'd6;

  localparam logic [CMD_W-1:0] CMD_GATE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CNOT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MEAS  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DUMP  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDA,
    S_RDB,
    S_LATB,
    S_MAC,
    S_WRA,
    S_WRB,
    S_MRD,
    S_MSQA,
    S_MSQB,
    S_MACC,
    S_MMUL,
    S_MEND,
    S_DRD,
    S_DOUT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic en;
    logic clr;
    logic sub;
  } mac_ctl_t;

  typedef struct packed {
    logic we;
    logic clr;
  } st_ctl_t;

endpackage

// ===== hdl/qubit_state_vector_engine_unit.sv =====
// State-vector engine for up to MAX_QUBITS qubits, amplitudes in signed Q2.F.
// Channels:
//   cfg  : cfg_valid/cfg_ready/cfg_data writes the active qubit count; always
//          ready, write it only while the engine is idle.
//   in   : in_valid/in_ready carries one command transaction; in_ready is high
//          only in the idle state.
//   out  : out_valid/out_ready returns results through an output register;
//          dump gives 2^n transactions, every other command gives one.
// Work, n active qubits, dim = 2^n, all on one shared multiply-accumulate
// unit and one amplitude store with one read and one write port:
//   gate    : per amplitude pair, two reads, 16 MAC steps and two writes
//   CNOT    : swapped pairs are read and written back, other pairs passed over
//   measure : squared magnitudes summed for the total, then the bit-serial
//             draw*total product, then a search over the entries
//   dump    : one entry at a time, waiting while the receiver stalls
//   clear, rejected command : straight to the result
// Reset: amplitude store returns to basis state 0 through per-entry valid
// bits, qubit count returns to 6, the output register empties.
// A stalled receiver holds the output register; the engine waits on it and
// takes no new command until its last result is loaded.
module qubit_state_vector_engine_unit #(
  parameter int MAX_QUBITS    = 6,
  parameter int AMP_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qsve_pkg::QCFG_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [qsve_pkg::CMD_W-1:0]          cmd,
  input  logic [2:0]                          target_qubit,
  input  logic [2:0]                          control_qubit,
  input  logic signed [qsve_pkg::GATE_W-1:0]  g00_re,
  input  logic signed [qsve_pkg::GATE_W-1:0]  g00_im,
  input  logic signed [qsve_pkg::GATE_W-1:0]  g01_re,
  input  logic signed [qsve_pkg::GATE_W-1:0]  g01_im,
  input  logic signed [qsve_pkg::GATE_W-1:0]  g10_re,
  input  logic signed [qsve_pkg::GATE_W-1:0]  g10_im,
  input  logic signed [qsve_pkg::GATE_W-1:0]  g11_re,
  input  logic signed [qsve_pkg::GATE_W-1:0]  g11_im,
  input  logic [qsve_pkg::DRAW_W-1:0]         rand_draw,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                status,
  output logic [qsve_pkg::IDX_W-1:0]          outcome,
  output logic [qsve_pkg::IDX_W-1:0]          amp_index,
  output logic signed [AMP_FRAC_BITS+1:0]     amp_re,
  output logic signed [AMP_FRAC_BITS+1:0]     amp_im,
  output logic                                last
);
  import qsve_pkg::*;

  localparam int MQ    = MAX_QUBITS;
  localparam int AMPW  = AMP_FRAC_BITS + 2;
  localparam int XW    = (AMPW > GATE_W) ? AMPW : GATE_W;
  localparam int ACCW  = XW + AMPW + 2;
  localparam int PS    = (AMP_FRAC_BITS > 16) ? 2 * (AMP_FRAC_BITS - 16) : 0;
  localparam int PW    = 2 * AMP_FRAC_BITS + 4 - PS;
  localparam int TW    = PW + MQ;
  localparam int DTW   = TW + DRAW_W;
  localparam int SCW   = 5;

  state_t state, state_next;

  logic [QCFG_W-1:0]       qcfg;
  logic [2:0]              n_cur, n_r;
  logic [CMD_W-1:0]        cmd_r;
  logic [2:0]              tq_r, cq_r;
  logic signed [GATE_W-1:0] g_r [8];
  logic [DRAW_W-1:0]       drw;
  logic                    rej_r;
  logic                    pass2;
  logic [MQ-1:0]           k;
  logic [SCW-1:0]          s;
  logic [MQ-1:0]           base_r;
  logic [MQ-1:0]           outcome_r;
  logic [TW-1:0]           total, cum, cum_new;
  logic [DTW-1:0]          dt;
  logic [PW-1:0]           p;
  logic                    found;

  logic signed [AMPW-1:0]  a_re, a_im, b_re, b_im;
  logic signed [AMPW-1:0]  ri_re, ri_im, rj_re, rj_im;

  logic [MQ-1:0]           full_mask, half_mask, low_mask, pair_i, pair_j, cm;
  logic                    k_full, k_half, out_free, accept, cmd_ok;

  mac_ctl_t                mac_ctl;
  st_ctl_t                 st_ctl;
  logic signed [XW-1:0]    mac_x;
  logic signed [AMPW-1:0]  mac_y;
  logic signed [ACCW-1:0]  mac_acc;
  logic signed [AMPW-1:0]  mac_rnd;
  logic [MQ-1:0]           raddr, waddr;
  logic signed [AMPW-1:0]  wre, wim, rre, rim;
  logic                    out_load;
  logic [1:0]              term, part;

  qsve_mac #(.XW(XW), .YW(AMPW)) u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .x   (mac_x),
    .y   (mac_y),
    .acc (mac_acc),
    .rnd (mac_rnd)
  );

  qsve_store #(.AB(MQ), .DW(AMPW)) u_store (
    .clk   (clk),
    .rst   (rst),
    .ctl   (st_ctl),
    .waddr (waddr),
    .wre   (wre),
    .wim   (wim),
    .raddr (raddr),
    .base  (base_r),
    .rre   (rre),
    .rim   (rim)
  );

  // active qubit count, clamped to 1..MAX_QUBITS
  always_comb begin
    if (qcfg == '0) begin
      n_cur = 3'd1;
    end else if (32'(qcfg) > MQ) begin
      n_cur = 3'(MQ);
    end else begin
      n_cur = qcfg;
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // reject bad qubit indices and unknown commands up front
  always_comb begin
    case (cmd)
      CMD_GATE:  cmd_ok = (target_qubit < n_cur);
      CMD_CNOT:  cmd_ok = (target_qubit < n_cur) && (control_qubit < n_cur) &&
                          (target_qubit != control_qubit);
      CMD_MEAS:  cmd_ok = 1'b1;
      CMD_DUMP:  cmd_ok = 1'b1;
      CMD_CLEAR: cmd_ok = 1'b1;
      default:   cmd_ok = 1'b0;
    endcase
  end

  // pair addressing: insert a zero at the target bit of the pair counter
  assign full_mask = ~({MQ{1'b1}} << n_r);
  assign half_mask = full_mask >> 1;
  assign low_mask  = ~({MQ{1'b1}} << tq_r);
  assign pair_i    = ((k & ~low_mask) << 1) | (k & low_mask);
  assign pair_j    = pair_i | (MQ'(1) << tq_r);
  assign cm        = MQ'(1) << cq_r;
  assign k_full    = (k == full_mask);
  assign k_half    = (k == half_mask);

  // measurement arithmetic
  assign p       = PW'($unsigned(mac_acc) >> PS);
  assign cum_new = cum + TW'(p);
  assign found   = {cum_new, {DRAW_W{1'b0}}} >= dt;

  // MAC operand selection for the gate: part 0 re_i, 1 im_i, 2 re_j, 3 im_j
  assign part = s[3:2];
  assign term = s[1:0];

  always_comb begin
    mac_x = XW'(g_r[{part[1], term}]);
    if (term[1]) begin
      mac_y = (term[0] ^ part[0]) ? b_im : b_re;
    end else begin
      mac_y = (term[0] ^ part[0]) ? a_im : a_re;
    end
    if (state == S_MSQA) begin
      mac_x = XW'(rre);
      mac_y = rre;
    end else if (state == S_MSQB) begin
      mac_x = XW'(rim);
      mac_y = rim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and strobes
  always_comb begin
    state_next = state;
    mac_ctl    = '0;
    st_ctl     = '0;
    raddr      = k;
    waddr      = pair_i;
    wre        = ri_re;
    wim        = ri_im;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (!cmd_ok) begin
            state_next = S_FIN;
          end else begin
            case (cmd)
              CMD_GATE:  state_next = S_RDA;
              CMD_CNOT:  state_next = S_RDA;
              CMD_MEAS:  state_next = S_MRD;
              CMD_DUMP:  state_next = S_DRD;
              CMD_CLEAR: begin
                state_next = S_FIN;
                st_ctl.clr = 1'b1;
              end
              default:   state_next = S_FIN;
            endcase
          end
        end
      end
      S_RDA: begin
        raddr = pair_i;
        if ((cmd_r == CMD_CNOT) && ((pair_i & cm) == '0)) begin
          state_next = k_half ? S_FIN : S_RDA;
        end else begin
          state_next = S_RDB;
        end
      end
      S_RDB: begin
        raddr      = pair_j;
        state_next = S_LATB;
      end
      S_LATB: begin
        raddr      = pair_j;
        state_next = (cmd_r == CMD_CNOT) ? S_WRA : S_MAC;
      end
      S_MAC: begin
        mac_ctl.en  = !s[4];
        mac_ctl.clr = (term == 2'd0);
        mac_ctl.sub = !part[0] && term[0];
        if (s[4]) begin
          state_next = S_WRA;
        end
      end
      S_WRA: begin
        st_ctl.we  = 1'b1;
        state_next = S_WRB;
      end
      S_WRB: begin
        st_ctl.we  = 1'b1;
        waddr      = pair_j;
        wre        = rj_re;
        wim        = rj_im;
        state_next = k_half ? S_FIN : S_RDA;
      end
      S_MRD: begin
        state_next = S_MSQA;
      end
      S_MSQA: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = 1'b1;
        state_next  = S_MSQB;
      end
      S_MSQB: begin
        mac_ctl.en = 1'b1;
        state_next = S_MACC;
      end
      S_MACC: begin
        if (!pass2) begin
          state_next = k_full ? S_MMUL : S_MRD;
        end else if (found || k_full) begin
          state_next = S_MEND;
        end else begin
          state_next = S_MRD;
        end
      end
      S_MMUL: begin
        if (s == SCW'(DRAW_W - 1)) begin
          state_next = S_MRD;
        end
      end
      S_MEND: begin
        st_ctl.clr = 1'b1;
        state_next = S_FIN;
      end
      S_DRD: begin
        state_next = S_DOUT;
      end
      S_DOUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = k_full ? S_IDLE : S_DRD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // configuration register and the store's basis mark
  always_ff @(posedge clk) begin
    if (rst) begin
      qcfg   <= QCFG_RESET;
      base_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        qcfg <= cfg_data;
      end
      if (accept && cmd_ok && (cmd == CMD_CLEAR)) begin
        base_r <= '0;
      end else if (state == S_MEND) begin
        base_r <= outcome_r;
      end
    end
  end

  // command capture, counters and work registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_r     <= cmd;
          tq_r      <= target_qubit;
          cq_r      <= control_qubit;
          g_r[0]    <= g00_re;
          g_r[1]    <= g00_im;
          g_r[2]    <= g01_re;
          g_r[3]    <= g01_im;
          g_r[4]    <= g10_re;
          g_r[5]    <= g10_im;
          g_r[6]    <= g11_re;
          g_r[7]    <= g11_im;
          drw       <= rand_draw;
          rej_r     <= !cmd_ok;
          n_r       <= n_cur;
          k         <= '0;
          s         <= '0;
          pass2     <= 1'b0;
          total     <= '0;
          cum       <= '0;
          dt        <= '0;
          outcome_r <= '0;
        end
      end
      S_RDA: begin
        if ((cmd_r == CMD_CNOT) && ((pair_i & cm) == '0)) begin
          k <= k + MQ'(1);
        end
      end
      S_RDB: begin
        a_re <= rre;
        a_im <= rim;
      end
      S_LATB: begin
        b_re  <= rre;
        b_im  <= rim;
        s     <= '0;
        // swap for CNOT: i takes j's value, j takes i's
        ri_re <= rre;
        ri_im <= rim;
        rj_re <= a_re;
        rj_im <= a_im;
      end
      S_MAC: begin
        s <= s + SCW'(1);
        case (s)
          SCW'(4):  ri_re <= mac_rnd;
          SCW'(8):  ri_im <= mac_rnd;
          SCW'(12): rj_re <= mac_rnd;
          SCW'(16): rj_im <= mac_rnd;
          default:  ;
        endcase
      end
      S_WRB: begin
        k <= k + MQ'(1);
      end
      S_MACC: begin
        if (!pass2) begin
          total <= total + TW'(p);
          if (k_full) begin
            s <= '0;
          end else begin
            k <= k + MQ'(1);
          end
        end else begin
          cum <= cum_new;
          if (found) begin
            outcome_r <= k;
          end else begin
            k <= k + MQ'(1);
          end
        end
      end
      S_MMUL: begin
        // bit-serial draw * total, most significant draw bit first
        dt  <= {dt[DTW-2:0], 1'b0} + (drw[DRAW_W-1] ? DTW'(total) : '0);
        drw <= {drw[DRAW_W-2:0], 1'b0};
        s   <= s + SCW'(1);
        if (s == SCW'(DRAW_W - 1)) begin
          pass2 <= 1'b1;
          k     <= '0;
        end
      end
      S_DOUT: begin
        if (out_free) begin
          k <= k + MQ'(1);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == S_DOUT) begin
        status    <= 1'b0;
        outcome   <= '0;
        amp_index <= IDX_W'(k);
        amp_re    <= rre;
        amp_im    <= rim;
        last      <= k_full;
      end else begin
        status    <= rej_r;
        outcome   <= (!rej_r && (cmd_r == CMD_MEAS)) ? IDX_W'(outcome_r) : '0;
        amp_index <= '0;
        amp_re    <= '0;
        amp_im    <= '0;
        last      <= 1'b1;
      end
    end
  end

  // store writes come only from the two write-back steps
  a_we_window: assert property (@(posedge clk) disable iff (rst)
    st_ctl.we |-> (state == S_WRA || state == S_WRB))
    else $error("amplitude store written outside write-back");

  // an accepted command always takes the engine out of the idle state
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("engine ready right after accepting a command");

  // a dump result carries the index of the entry just read
  a_dump_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_DOUT && out_load) |=> (out_valid && amp_index == IDX_W'($past(k))))
    else $error("dump index mismatch");

endmodule

// ===== hdl/qsve_mac.sv =====
module qsve_mac #(
  parameter int XW = 18,
  parameter int YW = 18
) (
  input  logic                     clk,
  input  qsve_pkg::mac_ctl_t       ctl,
  input  logic signed [XW-1:0]     x,
  input  logic signed [YW-1:0]     y,
  output logic signed [XW+YW+1:0]  acc,
  output logic signed [YW-1:0]     rnd
);
  import qsve_pkg::*;

  localparam int AW = XW + YW + 2;
  localparam int SW = AW - GATE_FRAC;
  localparam logic signed [AW-1:0] HALF = AW'(1) << (GATE_FRAC - 1);

  logic signed [XW+YW-1:0] prod;
  logic signed [AW-1:0]    acc_base;
  logic signed [AW-1:0]    biased;
  logic signed [SW-1:0]    sh;
  logic                    ovf;

  assign prod     = x * y;
  assign acc_base = ctl.clr ? '0 : acc;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.sub) begin
        acc <= acc_base - AW'(prod);
      end else begin
        acc <= acc_base + AW'(prod);
      end
    end
  end

  // round to nearest (ties up), then saturate to the amplitude range
  assign biased = acc + HALF;
  assign sh     = biased[AW-1:GATE_FRAC];
  assign ovf    = !((&sh[SW-1:YW-1]) || !(|sh[SW-1:YW-1]));

  always_comb begin
    if (ovf) begin
      rnd = sh[SW-1] ? {1'b1, {(YW-1){1'b0}}} : {1'b0, {(YW-1){1'b1}}};
    end else begin
      rnd = sh[YW-1:0];
    end
  end

endmodule

// ===== hdl/qsve_store.sv =====
module qsve_store #(
  parameter int AB = 6,
  parameter int DW = 18
) (
  input  logic                 clk,
  input  logic                 rst,
  input  qsve_pkg::st_ctl_t    ctl,
  input  logic [AB-1:0]        waddr,
  input  logic signed [DW-1:0] wre,
  input  logic signed [DW-1:0] wim,
  input  logic [AB-1:0]        raddr,
  input  logic [AB-1:0]        base,
  output logic signed [DW-1:0] rre,
  output logic signed [DW-1:0] rim
);
  import qsve_pkg::*;

  localparam int DEPTH = 1 << AB;
  localparam logic signed [DW-1:0] ONE = DW'(1) << (DW - 2);

  logic signed [DW-1:0] mem_re [DEPTH];
  logic signed [DW-1:0] mem_im [DEPTH];
  logic [DEPTH-1:0]     vld;

  // an entry never written since the last clear reads as basis vector "base"
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      vld <= '0;
    end else if (ctl.we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem_re[waddr] <= wre;
      mem_im[waddr] <= wim;
    end
  end

  always_ff @(posedge clk) begin
    if (vld[raddr]) begin
      rre <= mem_re[raddr];
      rim <= mem_im[raddr];
    end else begin
      rre <= (raddr == base) ? ONE : '0;
      rim <= '0;
    end
  end

endmodule
